// ----- hdl/tbe_pkg.sv -----
// ----------------------------------------------------------------------------
// tbe_pkg
// Shared types, widths and constants of the three-body energy solver.
// ----------------------------------------------------------------------------
package tbe_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 16;
  localparam int unsigned PHASE_W        = 32;
  localparam int unsigned N_ANG          = 6;
  localparam int unsigned N_OBJ          = 3;

  // rotation-mode CORDIC, Q4.30 datapath
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned CW           = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  // configuration
  localparam int unsigned BEAM_W     = 16;
  localparam int unsigned XSINE_W    = 24;
  localparam int unsigned DRIVE_W    = BEAM_W + XSINE_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [BEAM_W-1:0]  BEAM_RST  = 16'd8000;
  localparam logic [XSINE_W-1:0] XSINE_RST = 24'd117440;
  localparam logic [DRIVE_W-1:0] DRIVE_RST = 40'd939520000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BEAM  = 2'd0,
    CFG_XSINE = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OBJ_JET_ONE = 2'd0,
    OBJ_JET_TWO = 2'd1,
    OBJ_PHOTON  = 2'd2
  } obj_e;

  // solver widths
  localparam int unsigned RND_SH = 30;
  localparam int unsigned MW     = CW;        // matrix entries
  localparam int unsigned PW     = 2 * MW;    // products
  localparam int unsigned CFW    = 34;        // cofactors
  localparam int unsigned HALF   = CFW / 2;
  localparam int unsigned NPW    = DRIVE_W + HALF;
  localparam int unsigned DPW    = MW + CFW;  // determinant terms
  localparam int unsigned DW     = 64;        // determinant
  localparam int unsigned NSH    = 10;
  localparam int unsigned NW     = 84;        // dividend
  localparam int unsigned QW     = 32;        // quotient
  localparam int unsigned RW     = DW + 1;    // partial remainder
  localparam int unsigned EW     = 32;        // energies

  typedef struct packed {
    logic signed [CW-1:0] z;
    logic                 flip;
  } ang_t;

  typedef struct packed {
    ang_t [N_ANG-1:0] ang;
    logic [1:0]       choice;
  } item_t;

  function automatic logic [PHASE_W-1:0] atan_turn(input int unsigned i);
    logic [PHASE_W-1:0] r;
    unique case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051D;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2F9;
      15: r = 32'h0000517C;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A2F;
      19: r = 32'h00000517;
      20: r = 32'h0000028B;
      21: r = 32'h00000145;
      22: r = 32'h000000A2;
      23: r = 32'h00000051;
      24: r = 32'h00000028;
      25: r = 32'h00000014;
      26: r = 32'h0000000A;
      27: r = 32'h00000005;
      28: r = 32'h00000002;
      29: r = 32'h00000001;
      default: r = '0;
    endcase
    return r;
  endfunction

  // round half up at bit 30, floor shift
  function automatic logic signed [MW-1:0] rnd_m(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = (v + $signed(PW'(1) << (RND_SH - 1))) >>> RND_SH;
    return t[MW-1:0];
  endfunction

  function automatic logic signed [CFW-1:0] rnd_c(input logic signed [PW:0] v);
    logic signed [PW:0] t;
    t = (v + $signed((PW+1)'(1) << (RND_SH - 1))) >>> RND_SH;
    return t[CFW-1:0];
  endfunction

endpackage

// ----- hdl/tbe_front.sv -----
// ----------------------------------------------------------------------------
// tbe_front
// Takes requests, folds each angle to the right half turn and queues them.
// ----------------------------------------------------------------------------
module tbe_front import tbe_pkg::*; #(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ANGLE_BITS-1:0] angle_i [N_ANG],
  input  logic [1:0]            choice_i,
  input  logic                  pop_i,
  output logic                  q_vld_o,
  output item_t                 q_item_o
);

  item_t            item_d;
  item_t            mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             push;
  logic             pop;
  logic [PHASE_W-1:0] ph [N_ANG];

  always_comb begin
    item_d.choice = choice_i;
    for (int l = 0; l < N_ANG; l++) begin
      ph[l] = {angle_i[l], {(PHASE_W-ANGLE_BITS){1'b0}}};
      // second and third quarter: rotate by half a turn, negate at the end
      item_d.ang[l].flip = ph[l][PHASE_W-1] ^ ph[l][PHASE_W-2];
      item_d.ang[l].z = $signed({{(CW-PHASE_W){ph[l][PHASE_W-1] ^ item_d.ang[l].flip}},
                                 ph[l][PHASE_W-1] ^ item_d.ang[l].flip,
                                 ph[l][PHASE_W-2:0]});
    end
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i & ~in_stall_o;
  assign q_vld_o    = (cnt_q != 2'd0);
  assign pop        = pop_i & q_vld_o;
  assign q_item_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= item_d;
  end

endmodule

// ----- hdl/tbe_cordic.sv -----
// ----------------------------------------------------------------------------
// tbe_cordic
// Six-lane pipelined CORDIC, one rotation step per stage.
// ----------------------------------------------------------------------------
module tbe_cordic import tbe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  item_t                item_i,
  output logic                 vld_o,
  output logic signed [CW-1:0] cos_o [N_ANG],
  output logic signed [CW-1:0] sin_o [N_ANG],
  output logic [1:0]           choice_o
);

  logic [CORDIC_STEPS:0]  vld_q;
  logic signed [CW-1:0]   x_q [CORDIC_STEPS+1][N_ANG];
  logic signed [CW-1:0]   y_q [CORDIC_STEPS+1][N_ANG];
  logic signed [CW-1:0]   z_q [CORDIC_STEPS+1][N_ANG];
  logic [N_ANG-1:0]       flip_q [CORDIC_STEPS+1];
  logic [1:0]             ch_q [CORDIC_STEPS+1];
  logic                   out_vld_q;
  logic signed [CW-1:0]   cos_q [N_ANG];
  logic signed [CW-1:0]   sin_q [N_ANG];
  logic [1:0]             out_ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[CORDIC_STEPS-1:0], vld_i};
      out_vld_q <= vld_q[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ch_q[0] <= item_i.choice;
      for (int l = 0; l < N_ANG; l++) begin
        x_q[0][l]    <= CORDIC_GAIN;
        y_q[0][l]    <= '0;
        z_q[0][l]    <= item_i.ang[l].z;
        flip_q[0][l] <= item_i.ang[l].flip;
      end
      for (int s = 0; s < CORDIC_STEPS; s++) begin
        ch_q[s+1]   <= ch_q[s];
        flip_q[s+1] <= flip_q[s];
        for (int l = 0; l < N_ANG; l++) begin
          if (!z_q[s][l][CW-1]) begin
            x_q[s+1][l] <= x_q[s][l] - (y_q[s][l] >>> s);
            y_q[s+1][l] <= y_q[s][l] + (x_q[s][l] >>> s);
            z_q[s+1][l] <= z_q[s][l] - $signed({{(CW-PHASE_W){1'b0}}, atan_turn(s)});
          end else begin
            x_q[s+1][l] <= x_q[s][l] + (y_q[s][l] >>> s);
            y_q[s+1][l] <= y_q[s][l] - (x_q[s][l] >>> s);
            z_q[s+1][l] <= z_q[s][l] + $signed({{(CW-PHASE_W){1'b0}}, atan_turn(s)});
          end
        end
      end
      out_ch_q <= ch_q[CORDIC_STEPS];
      for (int l = 0; l < N_ANG; l++) begin
        cos_q[l] <= flip_q[CORDIC_STEPS][l] ? -x_q[CORDIC_STEPS][l] : x_q[CORDIC_STEPS][l];
        sin_q[l] <= flip_q[CORDIC_STEPS][l] ? -y_q[CORDIC_STEPS][l] : y_q[CORDIC_STEPS][l];
      end
    end
  end

  assign vld_o    = out_vld_q;
  assign cos_o    = cos_q;
  assign sin_o    = sin_q;
  assign choice_o = out_ch_q;

endmodule

// ----- hdl/tbe_solve.sv -----
// ----------------------------------------------------------------------------
// tbe_solve
// Direction matrix, cofactors, determinant and a pipelined restoring divider.
// ----------------------------------------------------------------------------
module tbe_solve import tbe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic signed [CW-1:0] cos_i [N_ANG],
  input  logic signed [CW-1:0] sin_i [N_ANG],
  input  logic [1:0]           choice_i,
  input  logic [DRIVE_W-1:0]   drive_i,
  output logic                 vld_o,
  output logic signed [EW-1:0] energy_o [N_OBJ],
  output logic signed [EW-1:0] chosen_o,
  output logic                 singular_o
);

  // stage map: A..G, divider 0..QW, final
  localparam int unsigned DV0  = 7;
  localparam int unsigned N_SV = DV0 + QW + 2;

  logic [N_SV-1:0] vld_q;
  logic [1:0]      ch_q [N_SV];

  logic signed [PW-1:0]  a_p [6];
  logic signed [MW-1:0]  a_m2 [N_OBJ];
  logic signed [MW-1:0]  b_m0 [N_OBJ], b_m1 [N_OBJ], b_m2 [N_OBJ];
  logic signed [PW-1:0]  c_p [6];
  logic signed [MW-1:0]  c_m0 [N_OBJ];
  logic signed [CFW-1:0] d_cof [N_OBJ];
  logic signed [MW-1:0]  d_m0 [N_OBJ];
  logic signed [DPW-1:0] e_p [N_OBJ];
  logic [NPW-1:0]        e_nl [N_OBJ], e_nh [N_OBJ];
  logic [N_OBJ-1:0]      e_cneg;
  logic signed [DW-1:0]  f_det;
  logic [NW-1:0]         f_num [N_OBJ];
  logic [N_OBJ-1:0]      f_cneg;
  logic [DW-1:0]         g_den;
  logic                  g_sing;
  logic [N_OBJ-1:0]      g_neg;
  logic [NW-1:0]         g_num [N_OBJ];

  logic [RW-1:0]         dv_r   [QW+1][N_OBJ];
  logic [QW-1:0]         dv_q   [QW+1][N_OBJ];
  logic [QW-1:0]         dv_lo  [QW+1][N_OBJ];
  logic [DW-1:0]         dv_den [QW+1];
  logic [N_OBJ-1:0]      dv_big [QW+1];
  logic [N_OBJ-1:0]      dv_neg [QW+1];
  logic                  dv_sing [QW+1];

  logic signed [EW-1:0]  z_e [N_OBJ];
  logic signed [EW-1:0]  z_pick;
  logic                  z_sing;

  logic [CFW-1:0]        cm [N_OBJ];
  logic [NW-1:0]         num_d [N_OBJ];
  logic [RW-1:0]         t [QW][N_OBJ];
  logic signed [EW-1:0]  e_d [N_OBJ];
  logic signed [EW-1:0]  pick_d;

  function automatic logic signed [EW-1:0] sat(input logic [QW-1:0] q, input logic big,
                                               input logic neg);
    logic signed [EW-1:0] r;
    if (neg) r = (big || q[QW-1]) ? {1'b1, {(EW-1){1'b0}}} : EW'(-q);
    else     r = (big || q[QW-1]) ? {1'b0, {(EW-1){1'b1}}} : EW'(q);
    return r;
  endfunction

  always_comb begin
    for (int j = 0; j < N_OBJ; j++) begin
      cm[j] = d_cof[j][CFW-1] ? CFW'(-d_cof[j]) : CFW'(d_cof[j]);
      num_d[j] = ({{(NW-NPW-HALF){1'b0}}, e_nh[j], {HALF{1'b0}}}
                 + {{(NW-NPW){1'b0}}, e_nl[j]}) << NSH;
    end
    for (int k = 0; k < QW; k++) begin
      for (int j = 0; j < N_OBJ; j++) begin
        t[k][j] = {dv_r[k][j][RW-2:0], dv_lo[k][j][QW-1-k]};
      end
    end
    for (int j = 0; j < N_OBJ; j++) begin
      e_d[j] = dv_sing[QW] ? '0 : sat(dv_q[QW][j], dv_big[QW][j], dv_neg[QW][j]);
    end
    unique case (ch_q[N_SV-2])
      OBJ_JET_ONE: pick_d = e_d[0];
      OBJ_JET_TWO: pick_d = e_d[1];
      OBJ_PHOTON:  pick_d = e_d[2];
      default:     pick_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N_SV-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ch_q[0] <= choice_i;
      for (int s = 1; s < N_SV; s++) ch_q[s] <= ch_q[s-1];

      // A: direction products
      for (int j = 0; j < N_OBJ; j++) begin
        a_p[j]   <= sin_i[2*j] * cos_i[2*j+1];
        a_p[3+j] <= sin_i[2*j] * sin_i[2*j+1];
        a_m2[j]  <= cos_i[2*j];
      end
      // B: matrix
      for (int j = 0; j < N_OBJ; j++) begin
        b_m0[j] <= rnd_m(a_p[j]);
        b_m1[j] <= rnd_m(a_p[3+j]);
        b_m2[j] <= a_m2[j];
      end
      // C: cofactor products
      c_p[0] <= b_m1[1] * b_m2[2];
      c_p[1] <= b_m1[2] * b_m2[1];
      c_p[2] <= b_m1[2] * b_m2[0];
      c_p[3] <= b_m1[0] * b_m2[2];
      c_p[4] <= b_m1[0] * b_m2[1];
      c_p[5] <= b_m1[1] * b_m2[0];
      c_m0   <= b_m0;
      // D: cofactors
      for (int j = 0; j < N_OBJ; j++) begin
        d_cof[j] <= rnd_c({c_p[2*j][PW-1], c_p[2*j]} - {c_p[2*j+1][PW-1], c_p[2*j+1]});
      end
      d_m0 <= c_m0;
      // E: determinant terms and dividend partial products
      for (int j = 0; j < N_OBJ; j++) begin
        e_p[j]    <= d_m0[j] * d_cof[j];
        e_nl[j]   <= drive_i * cm[j][HALF-1:0];
        e_nh[j]   <= drive_i * cm[j][CFW-1:HALF];
        e_cneg[j] <= d_cof[j][CFW-1];
      end
      // F
      f_det  <= DW'(e_p[0] + e_p[1] + e_p[2]);
      f_num  <= num_d;
      f_cneg <= e_cneg;
      // G
      g_den  <= f_det[DW-1] ? DW'(-f_det) : DW'(f_det);
      g_sing <= (f_det == '0);
      g_neg  <= f_cneg ^ {N_OBJ{f_det[DW-1]}};
      g_num  <= f_num;
      // divider setup: quotient overflows when dividend >= den << QW
      for (int j = 0; j < N_OBJ; j++) begin
        dv_big[0][j] <= {{(QW+DW-NW){1'b0}}, g_num[j]} >= {g_den, {QW{1'b0}}};
        dv_r[0][j]   <= {{(RW-(NW-QW)){1'b0}}, g_num[j][NW-1:QW]};
        dv_lo[0][j]  <= g_num[j][QW-1:0];
        dv_q[0][j]   <= '0;
      end
      dv_den[0]  <= g_den;
      dv_neg[0]  <= g_neg;
      dv_sing[0] <= g_sing;
      // one quotient bit per stage
      for (int k = 0; k < QW; k++) begin
        dv_den[k+1]  <= dv_den[k];
        dv_neg[k+1]  <= dv_neg[k];
        dv_big[k+1]  <= dv_big[k];
        dv_sing[k+1] <= dv_sing[k];
        for (int j = 0; j < N_OBJ; j++) begin
          dv_lo[k+1][j] <= dv_lo[k][j];
          if (t[k][j] >= {1'b0, dv_den[k]}) begin
            dv_r[k+1][j] <= t[k][j] - {1'b0, dv_den[k]};
            dv_q[k+1][j] <= {dv_q[k][j][QW-2:0], 1'b1};
          end else begin
            dv_r[k+1][j] <= t[k][j];
            dv_q[k+1][j] <= {dv_q[k][j][QW-2:0], 1'b0};
          end
        end
      end
      // final
      z_e    <= e_d;
      z_pick <= pick_d;
      z_sing <= dv_sing[QW];
    end
  end

  assign vld_o      = vld_q[N_SV-1];
  assign energy_o   = z_e;
  assign chosen_o   = z_pick;
  assign singular_o = z_sing;

endmodule

// ----- hdl/three_body_energy_from_angles_unit.sv -----
// ----------------------------------------------------------------------------
// three_body_energy_from_angles_unit
// Solves the energies of two jets and a photon from their direction angles.
// ----------------------------------------------------------------------------
// Accepts one angle set per clock while the input queue is not full and
// returns one result per request, in order. An accepted request lands in a
// two-entry input queue at the accepting edge, then passes 32 stages of
// pipelined CORDIC (entry, one rotation step per stage, exit), 7 stages of
// matrix and determinant math, a 33-stage restoring divider (a setup stage,
// then one quotient bit per stage), a select stage and the output register.
// The whole back end advances together whenever the output register is
// empty or being taken; the input queue keeps taking requests meanwhile
// until it fills. Config writes are meant for idle.
module three_body_energy_from_angles_unit import tbe_pkg::*; #(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ANGLE_BITS-1:0] jet_one_polar_i,
  input  logic [ANGLE_BITS-1:0] jet_one_azimuth_i,
  input  logic [ANGLE_BITS-1:0] jet_two_polar_i,
  input  logic [ANGLE_BITS-1:0] jet_two_azimuth_i,
  input  logic [ANGLE_BITS-1:0] photon_polar_i,
  input  logic [ANGLE_BITS-1:0] photon_azimuth_i,
  input  logic [1:0]            object_choice_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [EW-1:0]  chosen_energy_o,
  output logic signed [EW-1:0]  jet_one_energy_o,
  output logic signed [EW-1:0]  jet_two_energy_o,
  output logic signed [EW-1:0]  photon_energy_o,
  output logic                  singular_o
);

  logic [BEAM_W-1:0]    beam_q;
  logic [XSINE_W-1:0]   xsine_q;
  logic [DRIVE_W-1:0]   drive_q;

  logic [ANGLE_BITS-1:0] angle [N_ANG];
  logic                  en;
  logic                  q_vld;
  item_t                 q_item;
  logic                  cd_vld;
  logic signed [CW-1:0]  cd_cos [N_ANG];
  logic signed [CW-1:0]  cd_sin [N_ANG];
  logic [1:0]            cd_ch;
  logic                  sv_vld;
  logic signed [EW-1:0]  sv_e [N_OBJ];
  logic signed [EW-1:0]  sv_pick;
  logic                  sv_sing;

  logic                  out_vld_q;
  logic signed [EW-1:0]  pick_q, e0_q, e1_q, e2_q;
  logic                  sing_q;

  assign angle[0] = jet_one_polar_i;
  assign angle[1] = jet_one_azimuth_i;
  assign angle[2] = jet_two_polar_i;
  assign angle[3] = jet_two_azimuth_i;
  assign angle[4] = photon_polar_i;
  assign angle[5] = photon_azimuth_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_q  <= BEAM_RST;
      xsine_q <= XSINE_RST;
      drive_q <= DRIVE_RST;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_BEAM)  beam_q  <= cfg_data_i[BEAM_W-1:0];
      if (cfg_we_i && cfg_idx_i == CFG_XSINE) xsine_q <= cfg_data_i[XSINE_W-1:0];
      drive_q <= beam_q * xsine_q;
    end
  end

  assign en = ~out_vld_q | ~out_stall_i;

  tbe_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .angle_i    (angle),
    .choice_i   (object_choice_i),
    .pop_i      (en),
    .q_vld_o    (q_vld),
    .q_item_o   (q_item)
  );

  tbe_cordic u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (q_vld),
    .item_i   (q_item),
    .vld_o    (cd_vld),
    .cos_o    (cd_cos),
    .sin_o    (cd_sin),
    .choice_o (cd_ch)
  );

  tbe_solve u_solve (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .vld_i      (cd_vld),
    .cos_i      (cd_cos),
    .sin_i      (cd_sin),
    .choice_i   (cd_ch),
    .drive_i    (drive_q),
    .vld_o      (sv_vld),
    .energy_o   (sv_e),
    .chosen_o   (sv_pick),
    .singular_o (sv_sing)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= sv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && sv_vld) begin
      pick_q <= sv_pick;
      e0_q   <= sv_e[0];
      e1_q   <= sv_e[1];
      e2_q   <= sv_e[2];
      sing_q <= sv_sing;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign chosen_energy_o  = pick_q;
  assign jet_one_energy_o = e0_q;
  assign jet_two_energy_o = e1_q;
  assign photon_energy_o  = e2_q;
  assign singular_o       = sing_q;

endmodule

// ----- hdl/tbe_checker.sv -----
// ----------------------------------------------------------------------------
// tbe_checker
// Port-level checks of the energy solver, bound to the top level.
// ----------------------------------------------------------------------------
module tbe_checker import tbe_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic signed [EW-1:0] chosen_energy_o,
  input logic signed [EW-1:0] jet_one_energy_o,
  input logic signed [EW-1:0] jet_two_energy_o,
  input logic signed [EW-1:0] photon_energy_o,
  input logic                 singular_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(chosen_energy_o) && $stable(singular_o)
      && $stable(jet_one_energy_o) && $stable(jet_two_energy_o)
      && $stable(photon_energy_o))
    else $error("stalled result changed");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> jet_one_energy_o == '0 && jet_two_energy_o == '0
      && photon_energy_o == '0 && chosen_energy_o == '0)
    else $error("singular result with nonzero energy");

  a_pick_member: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> chosen_energy_o == '0 || chosen_energy_o == jet_one_energy_o
      || chosen_energy_o == jet_two_energy_o || chosen_energy_o == photon_energy_o)
    else $error("chosen energy matches no solved energy");

endmodule

bind three_body_energy_from_angles_unit tbe_checker u_tbe_checker (.*);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-body energy solver.
// ----------------------------------------------------------------------------
// A directed table, then random angle sets, go through the unit under several
// beam and crossing settings. Table rows may hold their result; a bit-exact
// software copy of the solver (CORDIC, cofactors, determinant, long division)
// predicts the rest. Both ends idle at random; one receiver hold-off backs up the unit.
module tb_top;
  import tbe_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;  // unmapped index
  localparam int ST_LIMIT = 20000;

  typedef struct packed {
    logic signed [31:0] chosen;
    logic signed [31:0] jet1;
    logic signed [31:0] jet2;
    logic signed [31:0] phot;
    logic               sing;
  } energies_t;

  typedef struct packed {
    logic [5:0][15:0] ang;
    logic [1:0]       choice;
    logic             typed;
    energies_t        res;
  } angle_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [5:0][15:0] ang = '0;
  logic [1:0] choice = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] chosen_e, jet1_e, jet2_e, phot_e;
  logic sing;

  logic [15:0] beam_sh;
  logic [23:0] xsine_sh;
  energies_t pending_energies[$];
  energies_t typed_q[$];
  logic typed_flag_q[$];
  int errors = 0, n_req = 0, n_res = 0, n_sing = 0, n_sat = 0, idle_cnt = 0;
  bit fast = 0, hold_req = 0;

  longint atan_tbl[30] = '{
    'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43,
    'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
    'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2F9,
    'h0000517C, 'h000028BE, 'h0000145F, 'h00000A2F, 'h00000517,
    'h0000028B, 'h00000145, 'h000000A2, 'h00000051, 'h00000028,
    'h00000014, 'h0000000A, 'h00000005, 'h00000002, 'h00000001};

  three_body_energy_from_angles_unit i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .jet_one_polar_i(ang[0]), .jet_one_azimuth_i(ang[1]),
    .jet_two_polar_i(ang[2]), .jet_two_azimuth_i(ang[3]),
    .photon_polar_i(ang[4]), .photon_azimuth_i(ang[5]),
    .object_choice_i(choice),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .chosen_energy_o(chosen_e), .jet_one_energy_o(jet1_e),
    .jet_two_energy_o(jet2_e), .photon_energy_o(phot_e), .singular_o(sing)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void turn_sincos(input logic [15:0] a, output longint cs,
                                      output longint sn);
    logic [31:0] ph;
    logic flip;
    longint x, y, z, nx;
    ph = {a, 16'h0};
    flip = ph[31] ^ ph[30];
    if (flip) ph = ph + 32'h80000000;
    z = longint'($signed(ph));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_tbl[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_tbl[i];
      end
      x = nx;
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic longint round_q30(input longint v);
    return (v + (longint'(1) << 29)) >>> 30;
  endfunction

  function automatic logic signed [31:0] solve_energy(input longint drive,
      input longint cof, input longint det);
    logic [127:0] num, den, q;
    logic neg;
    neg = (cof < 0) != (det < 0);
    num = 128'(drive << 10) * 128'(cof < 0 ? -cof : cof);
    den = 128'(det < 0 ? -det : det);
    q = num / den;
    if (neg) return (q >= 128'h8000_0000) ? 32'sh8000_0000 : -$signed(q[31:0]);
    return (q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
  endfunction

  function automatic energies_t predict_energies(input logic [5:0][15:0] a,
                                                 input logic [1:0] ch);
    longint c[6], s[6], m[3][3], cof[3], det, drive;
    energies_t r;
    logic signed [31:0] e[3];
    for (int k = 0; k < 6; k++) turn_sincos(a[k], c[k], s[k]);
    drive = longint'(beam_sh) * longint'(xsine_sh);
    m[0][0] = round_q30(s[0] * c[1]);
    m[0][1] = round_q30(s[2] * c[3]);
    m[0][2] = round_q30(s[4] * c[5]);
    m[1][0] = round_q30(s[0] * s[1]);
    m[1][1] = round_q30(s[2] * s[3]);
    m[1][2] = round_q30(s[4] * s[5]);
    m[2][0] = c[0];
    m[2][1] = c[2];
    m[2][2] = c[4];
    cof[0] = round_q30(m[1][1] * m[2][2] - m[1][2] * m[2][1]);
    cof[1] = round_q30(m[1][2] * m[2][0] - m[1][0] * m[2][2]);
    cof[2] = round_q30(m[1][0] * m[2][1] - m[1][1] * m[2][0]);
    det = m[0][0] * cof[0] + m[0][1] * cof[1] + m[0][2] * cof[2];
    for (int k = 0; k < 3; k++) e[k] = (det != 0) ? solve_energy(drive, cof[k], det) : 0;
    r.jet1 = e[0];
    r.jet2 = e[1];
    r.phot = e[2];
    case (ch)
      OBJ_JET_ONE: r.chosen = e[0];
      OBJ_JET_TWO: r.chosen = e[1];
      OBJ_PHOTON:  r.chosen = e[2];
      default:     r.chosen = 0;
    endcase
    r.sing = (det == 0);
    return r;
  endfunction

  // request side: predict on acceptance; config shadow follows the write port
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      beam_sh <= BEAM_RST;
      xsine_sh <= XSINE_RST;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_BEAM) beam_sh <= cfg_data[15:0];
        else if (cfg_idx == CFG_XSINE) xsine_sh <= cfg_data;
      end
      if (in_valid && !in_stall) begin
        energies_t p;
        p = predict_energies(ang, choice);
        if (typed_flag_q.size() && typed_flag_q.pop_front()) p = typed_q.pop_front();
        pending_energies.push_back(p);
        n_req++;
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      energies_t x;
      n_res++;
      if (pending_energies.size() == 0) begin
        $error("result with nothing pending");
        errors++;
      end else begin
        x = pending_energies.pop_front();
        if (x.sing) n_sing++;
        if (x.jet1 inside {32'sh7FFF_FFFF, 32'sh8000_0000}) n_sat++;
        if (chosen_e !== x.chosen) begin
          $error("chosen_energy exp %0d got %0d", x.chosen, chosen_e); errors++;
        end
        if (jet1_e !== x.jet1) begin
          $error("jet_one_energy exp %0d got %0d", x.jet1, jet1_e); errors++;
        end
        if (jet2_e !== x.jet2) begin
          $error("jet_two_energy exp %0d got %0d", x.jet2, jet2_e); errors++;
        end
        if (phot_e !== x.phot) begin
          $error("photon_energy exp %0d got %0d", x.phot, phot_e); errors++;
        end
        if (sing !== x.sing) begin
          $error("singular exp %0d got %0d", x.sing, sing); errors++;
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= ST_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      n = fast ? 0 : $urandom_range(0, 5);
      if (hold_req) begin
        n = 300;
        hold_req = 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  task automatic send_angles(input logic [5:0][15:0] a, input logic [1:0] ch);
    int n;
    n = fast ? 0 : $urandom_range(0, 5);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    ang <= a;
    choice <= ch;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] d);
    in_valid <= 1'b0;
    wait (pending_energies.size() == 0);
    repeat (80) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_batch(input int cnt);
    logic [5:0][15:0] a;
    for (int i = 0; i < cnt; i++) begin
      for (int k = 0; k < 6; k++) a[k] = 16'($urandom);
      case ($urandom_range(0, 9))
        0: begin  // identical directions, exactly singular
          a[2] = a[0]; a[3] = a[1]; a[4] = a[0]; a[5] = a[1];
        end
        1: begin  // nearly equal polar angles
          a[2] = a[0] + 16'($urandom_range(0, 3));
          a[4] = a[0] - 16'($urandom_range(0, 3));
        end
        default: ;
      endcase
      send_angles(a, 2'($urandom_range(0, 3)));
    end
  endtask

  localparam energies_t ZERO_SING = '{chosen: 0, jet1: 0, jet2: 0, phot: 0, sing: 1'b1};

  angle_row_t dir_tbl[14] = '{
    '{'0, OBJ_JET_ONE, 1'b1, ZERO_SING},
    '{{6{16'hFFFF}}, OBJ_PHOTON, 1'b1, ZERO_SING},
    '{{16'h1234, 16'h0777, 16'h1234, 16'h0777, 16'h1234, 16'h0777}, 2'd3, 1'b1,
      ZERO_SING},
    '{{16'h4000, 16'h0000, 16'h4000, 16'h4000, 16'h0000, 16'h0000}, OBJ_JET_ONE,
      1'b0, '0},
    '{{16'h4000, 16'h0000, 16'h4000, 16'h4000, 16'h0000, 16'h0000}, OBJ_JET_TWO,
      1'b0, '0},
    '{{16'h4000, 16'h0000, 16'h4000, 16'h4000, 16'h0000, 16'h0000}, OBJ_PHOTON,
      1'b0, '0},
    '{{16'h4000, 16'h0000, 16'h4000, 16'h4000, 16'h0000, 16'h0000}, 2'd3, 1'b0, '0},
    '{{16'hC000, 16'h8000, 16'h4000, 16'hC000, 16'h8000, 16'h2000}, OBJ_PHOTON,
      1'b0, '0},
    '{{16'h4000, 16'h0000, 16'h4000, 16'h0001, 16'h4000, 16'h0002}, OBJ_JET_ONE,
      1'b0, '0},
    '{{16'h4001, 16'h0000, 16'h3FFF, 16'h5555, 16'h4000, 16'hAAAA}, OBJ_JET_TWO,
      1'b0, '0},
    '{{16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE}, OBJ_JET_ONE,
      1'b0, '0},
    '{{16'h2AAA, 16'h5555, 16'hAAAA, 16'hD555, 16'h7FFF, 16'h8001}, OBJ_PHOTON,
      1'b0, '0},
    '{{16'h0100, 16'h0000, 16'h0080, 16'h8000, 16'h4000, 16'h4000}, OBJ_JET_TWO,
      1'b0, '0},
    '{{16'h6000, 16'h1111, 16'h2000, 16'h9999, 16'hE000, 16'h5A5A}, 2'd3, 1'b0, '0}
  };

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tbl[i]) begin
      typed_flag_q.push_back(dir_tbl[i].typed);
      if (dir_tbl[i].typed) typed_q.push_back(dir_tbl[i].res);
      send_angles(dir_tbl[i].ang, dir_tbl[i].choice);
    end
    random_batch(140);
    write_reg(CFG_BEAM, 24'hFFFFFF);
    write_reg(CFG_XSINE, 24'hFFFFFF);
    fast = 1;
    hold_req = 1;  // receiver backs off while requests keep coming
    random_batch(150);
    fast = 0;
    write_reg(CFG_BEAM, 24'h000000);
    write_reg(CFG_NONE, 24'h123456);
    random_batch(100);
    write_reg(CFG_BEAM, 24'h000001);
    write_reg(CFG_XSINE, 24'h000001);
    random_batch(100);
    write_reg(CFG_BEAM, 24'($urandom));
    write_reg(CFG_XSINE, 24'($urandom));
    random_batch(150);
    fast = 1;
    random_batch(100);
    in_valid <= 1'b0;
    wait (pending_energies.size() == 0);
    repeat (100) @(posedge clk);
    $display("Sent %0d angle sets over five register settings, %0d results checked",
             n_req, n_res);
    $display("Singular results: %0d, saturated first-jet energies: %0d", n_sing, n_sat);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/tbe_pkg.sv
hdl/tbe_front.sv
hdl/tbe_cordic.sv
hdl/tbe_solve.sv
hdl/three_body_energy_from_angles_unit.sv
hdl/tbe_checker.sv
test/tb_top.sv
